// ===== rtl/core/ebsd_pkg.sv =====
// package for the epoch bucket stack distance block
// constants, cell control struct and a saturating add helper; no dependencies
package ebsd_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int IDX_W       = $clog2(NUM_BUCKETS);
    localparam int NB_LOG      = $clog2(NUM_BUCKETS + 1) - 1;
    localparam int EPOCH_W     = 31;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = COUNT_W + IDX_W + 1;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W:0]   INT_MAX   = 33'h0_7FFF_FFFF;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic CFG_LOG_CAPACITY   = 1'b0;
    localparam logic CFG_LOG_FILL_LIMIT = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic               clear;     // reset all buckets
        logic               dec;       // decrement the selected bucket
        logic [IDX_W-1:0]   dec_idx;
        logic               merge;     // merge pair ending at merge_pos, shift below
        logic [IDX_W-1:0]   merge_pos;
        logic               inc0;      // count a key in bucket 0
    } t_cell_ctrl;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ebsd_cell.sv =====
// one bucket of the chain: epoch tag and key count
// uses ebsd_pkg; takes shift data from its newer neighbor
module ebsd_cell (
    input  logic                           i_clk,
    input  logic [ebsd_pkg::IDX_W-1:0]     i_pos,
    input  ebsd_pkg::t_cell_ctrl           i_ctrl,
    input  logic [ebsd_pkg::EPOCH_W-1:0]   i_prev_epoch,
    input  logic [ebsd_pkg::COUNT_W-1:0]   i_prev_count,
    output logic [ebsd_pkg::EPOCH_W-1:0]   o_epoch,
    output logic [ebsd_pkg::COUNT_W-1:0]   o_count
);
    import ebsd_pkg::*;

    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               is_first;

    assign is_first = (i_pos == '0);

    // next state from the broadcast command
    always_comb begin
        n_epoch = r_epoch;
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_epoch = '0;
            n_count = '0;
        end else if (i_ctrl.dec) begin
            if (i_pos == i_ctrl.dec_idx && r_count != '0) n_count = r_count - 1'b1;
        end else if (i_ctrl.merge) begin
            if (is_first) begin
                n_count = '0;
                if (r_epoch != EPOCH_MAX) n_epoch = r_epoch + 1'b1;
            end else if (i_pos == i_ctrl.merge_pos) begin
                n_count = sat_add(i_prev_count, r_count);
            end else if (i_pos < i_ctrl.merge_pos) begin
                n_epoch = i_prev_epoch;
                n_count = i_prev_count;
            end
        end else if (i_ctrl.inc0 && is_first) begin
            if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_epoch <= n_epoch;
        r_count <= n_count;
    end

    assign o_epoch = r_epoch;
    assign o_count = r_count;

endmodule

// ===== rtl/core/epoch_bucket_stack_distance.sv =====
// top level of the epoch bucket stack distance estimator
// uses ebsd_pkg and a row of ebsd_cell buckets
//
// A transaction is handled one at a time. An insert passes through the pair
// scan to the apply state. A lookup or delete first walks the bucket row one
// cell per cycle to find the matching bucket and the prefix sum, then
// decrements that bucket; a lookup then goes on through the pair scan. When
// bucket 0 is full, the scan over adjacent pairs finds the merge point and the
// whole row merges at once in the apply state before bucket 0 counts the key.
// A result that is not taken stalls the final step. The result sits in an
// output register so the next transaction is taken while it waits. A
// configuration write is accepted only when the block is idle with no result
// waiting, and clears all buckets in the following cycle.
module epoch_bucket_stack_distance (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_mode,
    input  logic [ebsd_pkg::EPOCH_W-1:0]   i_epoch,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ebsd_pkg::EPOCH_W-1:0]   o_current_epoch,
    output logic [31:0]                    o_stack_distance,
    output logic                           o_distance_valid,
    output logic                           o_capacity_doubled,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [4:0]                     i_cfg_data
);
    import ebsd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIND  = 5'b00010,
        S_DEC   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_APPLY = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [4:0]  r_log_cap, r_log_lim;
    logic [31:0] r_key_total;
    logic [32:0] r_key_cap;
    logic [31:0] r_fill_limit;
    logic        r_adaptive;
    logic        r_init;

    logic [1:0]         r_mode;
    logic [EPOCH_W-1:0] r_epoch_in;
    logic [IDX_W-1:0]   r_pos;
    logic [SUM_W-1:0]   r_sum;
    logic               r_found;
    logic [IDX_W-1:0]   r_idx;
    logic [COUNT_W:0]   r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_dbl;

    logic [EPOCH_W-1:0] cell_epoch [NUM_BUCKETS];
    logic [COUNT_W-1:0] cell_count [NUM_BUCKETS];
    t_cell_ctrl         ctrl;

    logic                out_free;
    logic                cfg_fire, in_fire;
    logic [IDX_W-1:0]    pos_i;
    logic [COUNT_W-1:0]  cur_count, prv_count;
    logic [COUNT_W:0]    pair_sum;
    logic                last_pos;

    assign out_free    = !o_valid || i_ready;
    assign o_cfg_ready = (r_state == S_IDLE) && !o_valid && !r_init;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_ready     = (r_state == S_IDLE) && !r_init && !cfg_fire;
    assign in_fire     = i_valid && o_ready;
    assign pos_i       = r_pos;
    assign cur_count   = cell_count[pos_i];
    assign prv_count   = cell_count[pos_i - 1'b1];
    assign pair_sum    = {1'b0, prv_count} + {1'b0, cur_count};
    assign last_pos    = (pos_i == IDX_W'(NUM_BUCKETS - 1));

    // bucket row
    for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
        ebsd_cell u_cell (
            .i_clk        (i_clk),
            .i_pos        (IDX_W'(g)),
            .i_ctrl       (ctrl),
            .i_prev_epoch (cell_epoch[(g == 0) ? 0 : g - 1]),
            .i_prev_count (cell_count[(g == 0) ? 0 : g - 1]),
            .o_epoch      (cell_epoch[g]),
            .o_count      (cell_count[g])
        );
    end

    // derived limits from the register values
    function automatic logic [31:0] lim_of(input logic [4:0] lc, input logic [4:0] lf);
        logic [4:0] e;
        e = (lf != '0) ? lf : ((lc > 5'(NB_LOG)) ? lc - 5'(NB_LOG) : 5'd0);
        return 32'd1 << e;
    endfunction

    logic need_merge;
    assign need_merge = (r_mode != MODE_DELETE) && (cell_count[0] >= r_fill_limit);

    // sequencer; a scan that found no pair below the limit merges the first pair
    always_comb begin
        n_state = r_state;
        ctrl    = '0;
        ctrl.clear = r_init;
        ctrl.dec_idx   = r_idx;
        ctrl.merge_pos = (r_best_idx == '0) ? IDX_W'(1) : r_best_idx;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = (i_mode == MODE_INSERT) ? S_SCAN :
                                   (i_mode == MODE_LOOKUP || i_mode == MODE_DELETE) ?
                                   S_FIND : S_APPLY;
            S_FIND:  if (last_pos || (!r_found && cell_epoch[pos_i] <= r_epoch_in))
                         n_state = S_DEC;
            S_DEC: begin
                ctrl.dec = 1'b1;
                n_state  = (r_mode == MODE_DELETE) ? S_APPLY : S_SCAN;
            end
            S_SCAN: begin
                if (!need_merge || last_pos) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    if (r_mode == MODE_INSERT || r_mode == MODE_LOOKUP) begin
                        ctrl.merge = need_merge;
                        ctrl.inc0  = !need_merge;
                    end
                    n_state = (need_merge && (r_mode == MODE_INSERT || r_mode == MODE_LOOKUP))
                              ? S_APPLY : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_log_cap   <= 5'd16;
            r_log_lim   <= 5'd0;
            r_init      <= 1'b1;
            o_valid     <= 1'b0;
            r_key_total <= '0;
            r_key_cap   <= 33'd1 << 16;
            r_fill_limit<= lim_of(5'd16, 5'd0);
            r_adaptive  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_init  <= cfg_fire;
            if (r_state == S_APPLY && out_free && !ctrl.merge) o_valid <= 1'b1;
            else if (o_valid && i_ready)                      o_valid <= 1'b0;
            if (r_init) begin
                r_key_total  <= '0;
                r_key_cap    <= 33'd1 << r_log_cap;
                r_fill_limit <= lim_of(r_log_cap, r_log_lim);
                r_adaptive   <= (r_log_lim == '0);
            end
            if (cfg_fire) begin
                if (i_cfg_index == CFG_LOG_CAPACITY) r_log_cap <= i_cfg_data;
                else                                 r_log_lim <= i_cfg_data;
            end
            if (in_fire) begin
                r_mode     <= i_mode;
                r_epoch_in <= i_epoch;
                r_pos      <= (i_mode == MODE_INSERT) ? IDX_W'(1) : '0;
                r_sum      <= '0;
                r_found    <= 1'b0;
                r_dbl      <= 1'b0;
                if (i_mode == MODE_INSERT) begin
                    if (r_key_total != '1) begin
                        r_key_total <= r_key_total + 1'b1;
                        if ({1'b0, r_key_total + 1'b1} > r_key_cap) begin
                            r_key_cap <= r_key_cap << 1;
                            r_dbl     <= 1'b1;
                            if (r_adaptive && r_fill_limit <= 32'h7FFF_FFFF)
                                r_fill_limit <= r_fill_limit << 1;
                        end
                    end else if ({1'b0, r_key_total} > r_key_cap) begin
                        r_key_cap <= r_key_cap << 1;
                        r_dbl     <= 1'b1;
                        if (r_adaptive && r_fill_limit <= 32'h7FFF_FFFF)
                            r_fill_limit <= r_fill_limit << 1;
                    end
                    r_best     <= INT_MAX;
                    r_best_idx <= '0;
                end
            end
            // find scan: one cell per cycle, accumulating the prefix sum
            if (r_state == S_FIND) begin
                r_sum <= r_sum + SUM_W'(cur_count);
                if (last_pos || cell_epoch[pos_i] <= r_epoch_in) begin
                    r_idx   <= pos_i;
                    r_found <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (r_state == S_DEC) begin
                r_pos      <= IDX_W'(1);
                r_best     <= INT_MAX;
                r_best_idx <= '0;
                if (r_mode == MODE_DELETE && r_key_total != '0)
                    r_key_total <= r_key_total - 1'b1;
            end
            // pair scan for the merge point, first least sum wins
            if (r_state == S_SCAN && need_merge) begin
                if (r_best > pair_sum) begin
                    r_best     <= pair_sum;
                    r_best_idx <= pos_i;
                end
                if (!last_pos) r_pos <= r_pos + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY && out_free && !ctrl.merge) begin
            o_current_epoch    <= cell_epoch[0];
            o_distance_valid   <= (r_mode == MODE_LOOKUP);
            o_capacity_doubled <= r_dbl;
            if (r_mode != MODE_LOOKUP || r_sum == '0)
                o_stack_distance <= '0;
            else if ((r_sum - 1'b1) > SUM_W'(COUNT_MAX))
                o_stack_distance <= COUNT_MAX;
            else
                o_stack_distance <= 32'(r_sum - 1'b1);
        end
    end

endmodule

// ===== sim/tb_epoch_bucket_stack_distance.sv =====
// testbench for epoch_bucket_stack_distance: random and directed accesses
// are checked against an in-bench bucket row predictor; depends on ebsd_pkg
`timescale 1ns / 1ps

module tb_epoch_bucket_stack_distance;
    import ebsd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         ROW_LAT     = 2 * NUM_BUCKETS + 12;

    typedef struct {
        logic [EPOCH_W-1:0] cur_epoch;
        logic [31:0]        distance;
        logic               dist_ok;
        logic               doubled;
    } t_access_result;

    // bucket row predictor plus queue of expected results
    class distance_board;
        logic [EPOCH_W-1:0] tag [NUM_BUCKETS];
        logic [COUNT_W-1:0] cnt [NUM_BUCKETS];
        logic [31:0]        key_total;
        logic [63:0]        key_cap;
        logic [31:0]        fill_lim;
        logic               adaptive;
        logic [4:0]         log_cap;
        logic [4:0]         log_fill;
        t_access_result     pending_q [$];
        int                 n_err;

        function void configure(logic idx, logic [4:0] val);
            if (idx == CFG_LOG_CAPACITY) begin
                log_cap = val;
            end else begin
                log_fill = val;
            end
            rebuild();
        endfunction

        function void rebuild();
            int lim;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                tag[i] = '0;
                cnt[i] = '0;
            end
            key_total = 0;
            key_cap   = 64'd1 << log_cap;
            adaptive  = (log_fill == 0);
            if (adaptive) begin
                lim = (log_cap > NB_LOG) ? log_cap - NB_LOG : 0;
            end else begin
                lim = log_fill;
            end
            fill_lim = 32'd1 << lim;
        endfunction

        function int find_bucket(logic [EPOCH_W-1:0] ep);
            for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
                if (tag[i] <= ep) return i;
            end
            return NUM_BUCKETS - 1;
        endfunction

        // merge the cheapest adjacent pair and open a new bucket 0
        function void merge_cheapest();
            int          m;
            logic [63:0] best;
            logic [63:0] s;
            m    = 0;
            best = 64'h7FFF_FFFF;
            for (int i = 1; i < NUM_BUCKETS; i++) begin
                s = 64'(cnt[i-1]) + 64'(cnt[i]);
                if (best > s) begin
                    best = s;
                    m    = i;
                end
            end
            if (m == 0) begin
                m    = 1;
                best = 64'(cnt[0]) + 64'(cnt[1]);
            end
            cnt[m] = (best > 64'(COUNT_MAX)) ? COUNT_MAX : best[31:0];
            for (int i = m - 1; i > 0; i--) begin
                tag[i] = tag[i-1];
                cnt[i] = cnt[i-1];
            end
            cnt[0] = '0;
            if (tag[0] != EPOCH_MAX) tag[0] = tag[0] + 1'b1;
        endfunction

        function void count_newest();
            if (cnt[0] >= fill_lim) merge_cheapest();
            if (cnt[0] != COUNT_MAX) cnt[0] = cnt[0] + 1;
        endfunction

        function void note_access(logic [1:0] mode, logic [EPOCH_W-1:0] ep);
            t_access_result r;
            int             idx;
            logic [63:0]    sum;
            r.distance = '0;
            r.dist_ok  = 1'b0;
            r.doubled  = 1'b0;
            case (mode)
                MODE_INSERT: begin
                    if (key_total != 32'hFFFF_FFFF) key_total++;
                    if (64'(key_total) > key_cap) begin
                        key_cap   = key_cap << 1;
                        r.doubled = 1'b1;
                        if (adaptive && fill_lim <= 32'h7FFF_FFFF) fill_lim = fill_lim << 1;
                    end
                    count_newest();
                end
                MODE_LOOKUP: begin
                    idx = find_bucket(ep);
                    sum = 0;
                    for (int i = 0; i <= idx; i++) sum += 64'(cnt[i]);
                    if (cnt[idx] != 0) cnt[idx] = cnt[idx] - 1;
                    if (sum > 64'h1_0000_0000) begin
                        r.distance = 32'hFFFF_FFFF;
                    end else if (sum != 0) begin
                        r.distance = 32'(sum - 1);
                    end
                    r.dist_ok = 1'b1;
                    count_newest();
                end
                MODE_DELETE: begin
                    idx = find_bucket(ep);
                    if (cnt[idx] != 0) cnt[idx] = cnt[idx] - 1;
                    if (key_total != 0) key_total--;
                end
                default: begin
                end
            endcase
            r.cur_epoch = tag[0];
            pending_q.push_back(r);
        endfunction

        function void check_result(t_access_result got);
            t_access_result exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing expected, epoch %0d dist %0d",
                         $time, got.cur_epoch, got.distance);
                n_err++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.cur_epoch !== exp_r.cur_epoch) begin
                $display("%0t: current_epoch exp %0d got %0d", $time,
                         exp_r.cur_epoch, got.cur_epoch);
                n_err++;
            end
            if (got.distance !== exp_r.distance) begin
                $display("%0t: stack_distance exp %0d got %0d", $time,
                         exp_r.distance, got.distance);
                n_err++;
            end
            if (got.dist_ok !== exp_r.dist_ok) begin
                $display("%0t: distance_valid exp %0b got %0b", $time,
                         exp_r.dist_ok, got.dist_ok);
                n_err++;
            end
            if (got.doubled !== exp_r.doubled) begin
                $display("%0t: capacity_doubled exp %0b got %0b", $time,
                         exp_r.doubled, got.doubled);
                n_err++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_mode = MODE_INSERT;
    logic [EPOCH_W-1:0] i_epoch = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [EPOCH_W-1:0] o_current_epoch;
    logic [31:0]        o_stack_distance;
    logic               o_distance_valid;
    logic               o_capacity_doubled;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_LOG_CAPACITY;
    logic [4:0]         i_cfg_data = '0;

    distance_board     board;
    logic [EPOCH_W-1:0] live_keys [$];
    bit                 no_idle;

    epoch_bucket_stack_distance u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // one input transaction, entered and left at a falling edge
    task automatic send_access(logic [1:0] mode, logic [EPOCH_W-1:0] ep);
        repeat (idle_len()) @(negedge i_clk);
        i_valid = 1'b1;
        i_mode  = mode;
        i_epoch = ep;
        do @(posedge i_clk); while (!o_ready);
        board.note_access(mode, ep);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.configure(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0) @(negedge i_clk);
        repeat (ROW_LAT) @(negedge i_clk);
    endtask

    // random accesses mostly on live keys so merges and deep lookups happen
    task automatic random_phase(int n);
        int                 r;
        int                 j;
        logic [EPOCH_W-1:0] ep;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (live_keys.size() > 250 && r < 45) r = 80;
            if (r < 45 || live_keys.size() == 0) begin
                send_access(MODE_INSERT, EPOCH_W'($urandom));
                live_keys.push_back(board.tag[0]);
            end else if (r < 78) begin
                j = $urandom_range(0, live_keys.size() - 1);
                send_access(MODE_LOOKUP, live_keys[j]);
                live_keys[j] = board.tag[0];
            end else if (r < 92) begin
                j = $urandom_range(0, live_keys.size() - 1);
                send_access(MODE_DELETE, live_keys[j]);
                live_keys.delete(j);
            end else begin
                ep = ($urandom_range(0, 1) == 1) ? EPOCH_W'($urandom) : board.tag[0];
                send_access(2'($urandom_range(0, 3)), ep);
            end
        end
    endtask

    // result side: random stalls, checks at the rising edge
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
                stall   = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_access_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.cur_epoch = o_current_epoch;
            got.distance  = o_stack_distance;
            got.dist_ok   = o_distance_valid;
            got.doubled   = o_capacity_doubled;
            board.check_result(got);
        end
    end

    initial begin
        #50ms;
        $display("epoch_bucket_stack_distance test failed");
        $finish;
    end

    initial begin
        logic [4:0] caps  [6];
        logic [4:0] fills [6];
        caps           = '{5'd0, 5'd0, 5'd3, 5'd31, 5'd7, 5'd2};
        fills          = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd0, 5'd3};
        board          = new();
        board.n_err    = 0;
        board.log_cap  = 5'd16;
        board.log_fill = 5'd0;
        board.rebuild();
        no_idle = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty row, epoch extremes, unknown mode, first inserts
        send_access(MODE_DELETE, '0);
        send_access(MODE_LOOKUP, EPOCH_MAX);
        send_access(MODE_UNUSED, EPOCH_MAX);
        send_access(MODE_INSERT, '0);
        send_access(MODE_LOOKUP, '0);
        send_access(MODE_LOOKUP, EPOCH_MAX);
        send_access(MODE_INSERT, EPOCH_MAX);
        send_access(MODE_DELETE, EPOCH_MAX);
        send_access(MODE_DELETE, '0);
        send_access(MODE_DELETE, '0);
        send_access(MODE_UNUSED, '0);
        random_phase(200);

        // each setting restarts the row; extremes and adaptive modes included
        for (int p = 0; p < 6; p++) begin
            drain();
            live_keys.delete();
            write_reg(CFG_LOG_CAPACITY, caps[p]);
            write_reg(CFG_LOG_FILL_LIMIT, fills[p]);
            no_idle = (p == 2);
            if (p == 0) begin
                // capacity one: the second and third inserts double it, the fourth does not
                send_access(MODE_INSERT, '0);
                send_access(MODE_INSERT, '0);
                send_access(MODE_INSERT, '0);
                send_access(MODE_LOOKUP, '0);
                send_access(MODE_INSERT, '0);
            end
            random_phase(240);
        end

        drain();
        if (board.n_err == 0 && board.pending_q.size() == 0) begin
            $display("epoch_bucket_stack_distance test passed");
        end else begin
            $display("epoch_bucket_stack_distance test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ebsd_pkg.sv
rtl/core/ebsd_cell.sv
rtl/core/epoch_bucket_stack_distance.sv
sim/tb_epoch_bucket_stack_distance.sv
